// File: rtl/srcomp_pkg.sv
// Shared types, constants and the microprogram of the sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none
package srcomp_pkg;

    // Commands on the input side, echoed as quantity on the output side
    localparam logic [1:0] CMD_TEMP  = 2'd0;
    localparam logic [1:0] CMD_PRESS = 2'd1;
    localparam logic [1:0] CMD_HUM   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_TEMP    = 3'd0;
    localparam logic [2:0] REG_PRESS_A = 3'd1;
    localparam logic [2:0] REG_PRESS_B = 3'd2;
    localparam logic [2:0] REG_PRESS_C = 3'd3;
    localparam logic [2:0] REG_HUM_A   = 3'd4;
    localparam logic [2:0] REG_HUM_B   = 3'd5;

    // Microprogram entry points and the last valid address
    localparam logic [6:0] PC_TEMP  = 7'd0;
    localparam logic [6:0] PC_PRESS = 7'd16;
    localparam logic [6:0] PC_HUM   = 7'd51;
    localparam logic [6:0] PC_LAST  = 7'd79;

    // Upper humidity clamp before the final shift
    localparam logic [63:0] HUM_MAX = 64'd419430400;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_SHL,
        OP_ASR,
        OP_MUL,
        OP_DIV,
        OP_ZCHK,
        OP_CLAMP,
        OP_DONE
    } op_t;

    typedef enum logic [4:0] {
        S_R0, S_R1, S_R2, S_R3, S_FT, S_RAW, S_RAWH, S_IMM,
        S_T1, S_T2, S_T3,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_H1, S_H2, S_H3, S_H4, S_H5, S_H6
    } src_t;

    typedef enum logic [2:0] {
        D_R0, D_R1, D_R2, D_R3, D_FT
    } dst_t;

    typedef struct packed {
        op_t         op;
        dst_t        dst;
        src_t        sa;
        src_t        sb;
        logic [5:0]  sh;
        logic [31:0] imm;
    } uinst_t;

    // Control of the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
        logic w32;
    } md_ctl_t;

    function automatic uinst_t mk(op_t op, dst_t d, src_t a, src_t b,
                                  logic [5:0] sh, logic [31:0] imm);
        uinst_t u;
        u.op  = op;
        u.dst = d;
        u.sa  = a;
        u.sb  = b;
        u.sh  = sh;
        u.imm = imm;
        return u;
    endfunction

    // Microprogram: temperature, pressure and humidity sequences
    function automatic uinst_t ucode(logic [6:0] pc);
        uinst_t u;
        case (pc)
            // temperature
            7'd0:  u = mk(OP_ASR, D_R0, S_RAW, S_IMM, 6'd3, 32'd0);
            7'd1:  u = mk(OP_SHL, D_R1, S_T1, S_IMM, 6'd1, 32'd0);
            7'd2:  u = mk(OP_SUB, D_R0, S_R0, S_R1, 6'd0, 32'd0);
            7'd3:  u = mk(OP_MUL, D_R0, S_R0, S_T2, 6'd0, 32'd0);
            7'd4:  u = mk(OP_ASR, D_R0, S_R0, S_IMM, 6'd11, 32'd0);
            7'd5:  u = mk(OP_ASR, D_R1, S_RAW, S_IMM, 6'd4, 32'd0);
            7'd6:  u = mk(OP_SUB, D_R1, S_R1, S_T1, 6'd0, 32'd0);
            7'd7:  u = mk(OP_MUL, D_R1, S_R1, S_R1, 6'd0, 32'd0);
            7'd8:  u = mk(OP_ASR, D_R1, S_R1, S_IMM, 6'd12, 32'd0);
            7'd9:  u = mk(OP_MUL, D_R1, S_R1, S_T3, 6'd0, 32'd0);
            7'd10: u = mk(OP_ASR, D_R1, S_R1, S_IMM, 6'd14, 32'd0);
            7'd11: u = mk(OP_ADD, D_FT, S_R0, S_R1, 6'd0, 32'd0);
            7'd12: u = mk(OP_MUL, D_R0, S_FT, S_IMM, 6'd0, 32'd5);
            7'd13: u = mk(OP_ADD, D_R0, S_R0, S_IMM, 6'd0, 32'd128);
            7'd14: u = mk(OP_ASR, D_R0, S_R0, S_IMM, 6'd8, 32'd0);
            7'd15: u = mk(OP_DONE, D_R0, S_R0, S_IMM, 6'd0, 32'd0);
            // pressure
            7'd16: u = mk(OP_SUB, D_R0, S_FT, S_IMM, 6'd0, 32'd128000);
            7'd17: u = mk(OP_MUL, D_R1, S_R0, S_R0, 6'd0, 32'd0);
            7'd18: u = mk(OP_MUL, D_R2, S_R1, S_P6, 6'd0, 32'd0);
            7'd19: u = mk(OP_MUL, D_R3, S_R0, S_P5, 6'd0, 32'd0);
            7'd20: u = mk(OP_SHL, D_R3, S_R3, S_IMM, 6'd17, 32'd0);
            7'd21: u = mk(OP_ADD, D_R2, S_R2, S_R3, 6'd0, 32'd0);
            7'd22: u = mk(OP_SHL, D_R3, S_P4, S_IMM, 6'd35, 32'd0);
            7'd23: u = mk(OP_ADD, D_R2, S_R2, S_R3, 6'd0, 32'd0);
            7'd24: u = mk(OP_MUL, D_R1, S_R1, S_P3, 6'd0, 32'd0);
            7'd25: u = mk(OP_ASR, D_R1, S_R1, S_IMM, 6'd8, 32'd0);
            7'd26: u = mk(OP_MUL, D_R3, S_R0, S_P2, 6'd0, 32'd0);
            7'd27: u = mk(OP_SHL, D_R3, S_R3, S_IMM, 6'd12, 32'd0);
            7'd28: u = mk(OP_ADD, D_R1, S_R1, S_R3, 6'd0, 32'd0);
            7'd29: u = mk(OP_SHL, D_R3, S_IMM, S_IMM, 6'd47, 32'd1);
            7'd30: u = mk(OP_ADD, D_R1, S_R1, S_R3, 6'd0, 32'd0);
            7'd31: u = mk(OP_MUL, D_R1, S_R1, S_P1, 6'd0, 32'd0);
            7'd32: u = mk(OP_ASR, D_R1, S_R1, S_IMM, 6'd33, 32'd0);
            7'd33: u = mk(OP_ZCHK, D_R1, S_R1, S_IMM, 6'd0, 32'd0);
            7'd34: u = mk(OP_SUB, D_R0, S_IMM, S_RAW, 6'd0, 32'd1048576);
            7'd35: u = mk(OP_SHL, D_R0, S_R0, S_IMM, 6'd31, 32'd0);
            7'd36: u = mk(OP_SUB, D_R0, S_R0, S_R2, 6'd0, 32'd0);
            7'd37: u = mk(OP_MUL, D_R0, S_R0, S_IMM, 6'd0, 32'd3125);
            7'd38: u = mk(OP_DIV, D_R0, S_R0, S_R1, 6'd0, 32'd0);
            7'd39: u = mk(OP_ASR, D_R1, S_R0, S_IMM, 6'd13, 32'd0);
            7'd40: u = mk(OP_MUL, D_R2, S_P9, S_R1, 6'd0, 32'd0);
            7'd41: u = mk(OP_MUL, D_R2, S_R2, S_R1, 6'd0, 32'd0);
            7'd42: u = mk(OP_ASR, D_R2, S_R2, S_IMM, 6'd25, 32'd0);
            7'd43: u = mk(OP_MUL, D_R3, S_P8, S_R0, 6'd0, 32'd0);
            7'd44: u = mk(OP_ASR, D_R3, S_R3, S_IMM, 6'd19, 32'd0);
            7'd45: u = mk(OP_ADD, D_R0, S_R0, S_R2, 6'd0, 32'd0);
            7'd46: u = mk(OP_ADD, D_R0, S_R0, S_R3, 6'd0, 32'd0);
            7'd47: u = mk(OP_ASR, D_R0, S_R0, S_IMM, 6'd8, 32'd0);
            7'd48: u = mk(OP_SHL, D_R1, S_P7, S_IMM, 6'd4, 32'd0);
            7'd49: u = mk(OP_ADD, D_R0, S_R0, S_R1, 6'd0, 32'd0);
            7'd50: u = mk(OP_DONE, D_R0, S_R0, S_IMM, 6'd0, 32'd0);
            // humidity
            7'd51: u = mk(OP_SUB, D_R0, S_FT, S_IMM, 6'd0, 32'd76800);
            7'd52: u = mk(OP_SHL, D_R1, S_RAWH, S_IMM, 6'd14, 32'd0);
            7'd53: u = mk(OP_SHL, D_R2, S_H4, S_IMM, 6'd20, 32'd0);
            7'd54: u = mk(OP_SUB, D_R1, S_R1, S_R2, 6'd0, 32'd0);
            7'd55: u = mk(OP_MUL, D_R2, S_H5, S_R0, 6'd0, 32'd0);
            7'd56: u = mk(OP_SUB, D_R1, S_R1, S_R2, 6'd0, 32'd0);
            7'd57: u = mk(OP_ADD, D_R1, S_R1, S_IMM, 6'd0, 32'd16384);
            7'd58: u = mk(OP_ASR, D_R1, S_R1, S_IMM, 6'd15, 32'd0);
            7'd59: u = mk(OP_MUL, D_R2, S_R0, S_H3, 6'd0, 32'd0);
            7'd60: u = mk(OP_ASR, D_R2, S_R2, S_IMM, 6'd11, 32'd0);
            7'd61: u = mk(OP_ADD, D_R2, S_R2, S_IMM, 6'd0, 32'd32768);
            7'd62: u = mk(OP_MUL, D_R3, S_R0, S_H6, 6'd0, 32'd0);
            7'd63: u = mk(OP_ASR, D_R3, S_R3, S_IMM, 6'd10, 32'd0);
            7'd64: u = mk(OP_MUL, D_R3, S_R3, S_R2, 6'd0, 32'd0);
            7'd65: u = mk(OP_ASR, D_R3, S_R3, S_IMM, 6'd10, 32'd0);
            7'd66: u = mk(OP_ADD, D_R3, S_R3, S_IMM, 6'd0, 32'd2097152);
            7'd67: u = mk(OP_MUL, D_R3, S_R3, S_H2, 6'd0, 32'd0);
            7'd68: u = mk(OP_ADD, D_R3, S_R3, S_IMM, 6'd0, 32'd8192);
            7'd69: u = mk(OP_ASR, D_R3, S_R3, S_IMM, 6'd14, 32'd0);
            7'd70: u = mk(OP_MUL, D_R0, S_R1, S_R3, 6'd0, 32'd0);
            7'd71: u = mk(OP_ASR, D_R1, S_R0, S_IMM, 6'd15, 32'd0);
            7'd72: u = mk(OP_MUL, D_R1, S_R1, S_R1, 6'd0, 32'd0);
            7'd73: u = mk(OP_ASR, D_R1, S_R1, S_IMM, 6'd7, 32'd0);
            7'd74: u = mk(OP_MUL, D_R1, S_R1, S_H1, 6'd0, 32'd0);
            7'd75: u = mk(OP_ASR, D_R1, S_R1, S_IMM, 6'd4, 32'd0);
            7'd76: u = mk(OP_SUB, D_R0, S_R0, S_R1, 6'd0, 32'd0);
            7'd77: u = mk(OP_CLAMP, D_R0, S_R0, S_IMM, 6'd0, 32'd0);
            7'd78: u = mk(OP_ASR, D_R0, S_R0, S_IMM, 6'd12, 32'd0);
            7'd79: u = mk(OP_DONE, D_R0, S_R0, S_IMM, 6'd0, 32'd0);
            default: u = mk(OP_DONE, D_R0, S_IMM, S_IMM, 6'd0, 32'd0);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: rtl/srcomp_muldiv.sv
// Shared bit-serial multiplier and signed restoring divider, 64-bit wrapping.
`timescale 1ns / 1ps
`default_nettype none
module srcomp_muldiv
    import srcomp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire md_ctl_t     ctl,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             busy,
    output logic             done,
    output logic [63:0]      result
);

    logic        busy_reg;
    logic        done_reg;
    logic        div_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] rem_reg;

    logic [64:0] rem_sh;
    logic        rem_ge;
    logic [64:0] rem_dif;

    // one divide step: shift in the next dividend bit, trial subtract
    always_comb
    begin
        rem_sh  = {rem_reg, a_reg[63]};
        rem_ge  = (rem_sh >= {1'b0, b_reg});
        rem_dif = rem_sh - {1'b0, b_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                div_reg  <= ctl.is_div;
                cnt_reg  <= (ctl.w32 && !ctl.is_div) ? 7'd32 : 7'd64;
                acc_reg  <= 64'd0;
                rem_reg  <= 64'd0;
                if (ctl.is_div)
                begin
                    a_reg   <= a[63] ? (64'd0 - a) : a;
                    b_reg   <= b[63] ? (64'd0 - b) : b;
                    neg_reg <= a[63] ^ b[63];
                end
                else
                begin
                    a_reg   <= a;
                    b_reg   <= b;
                    neg_reg <= 1'b0;
                end
            end
            else if (busy_reg)
            begin
                if (div_reg)
                begin
                    if (rem_ge)
                    begin
                        rem_reg <= rem_dif[63:0];
                        a_reg   <= {a_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[63:0];
                        a_reg   <= {a_reg[62:0], 1'b0};
                    end
                end
                else
                begin
                    // shift-add: one multiplier bit per cycle
                    if (b_reg[0])
                    begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= {a_reg[62:0], 1'b0};
                    b_reg <= {1'b0, b_reg[63:1]};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (64'd0 - a_reg) : a_reg) : acc_reg;

endmodule
`default_nettype wire

// File: rtl/sensor_reading_compensation.sv
// Top level: microcoded integer compensation of temperature, pressure, humidity.
//
// Input stream s_*: s_tuser carries the command, s_tdata the raw sample. One
// request is taken at a time; s_tready is high only while the block is idle.
// Output stream m_*: one result per request, quantity in m_tuser and the
// compensated value in m_tdata. The result sits in an output register until
// taken; a stalled receiver holds it there, and the next request may be
// accepted meanwhile but its result waits until the register frees.
// Run time is set by the shared shift-add multiplier (one bit a cycle) and the
// restoring divider (64 steps), plus the ALU microsteps; a 32-bit multiply is
// shorter than a 64-bit multiply or divide. A pressure request with a zero
// divisor stops early, and an unused command goes straight to the finish state.
// s_tready rises with m_tvalid, so a new request is taken only once the
// previous result has entered the output register.
// Configuration: cfg_we/cfg_index/cfg_data write one calibration register per
// cycle; write only while idle. Reset clears calibration, the stored fine
// temperature and all control state.
`timescale 1ns / 1ps
`default_nettype none
module sensor_reading_compensation
    import srcomp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // raw_sample [19:0], zero fill
    input  wire logic [1:0]  s_tuser,   // command [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // compensated_value [31:0]
    output logic [1:0]       m_tuser,   // quantity [1:0]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  pc_reg, pc_next;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;
    logic [31:0] hum_a_reg;
    logic [39:0] hum_b_reg;
    logic [31:0] ft_reg;

    logic [1:0]  cmd_reg;
    logic [19:0] raw_reg;
    logic        w32_reg;
    logic [31:0] fin_reg;
    logic [63:0] r0_reg, r1_reg, r2_reg, r3_reg;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    uinst_t      ui;
    logic [63:0] va, vb, alu, wb_raw, wb_val;
    logic        wr_en;
    md_ctl_t     md_ctl;
    logic        md_busy, md_done;
    logic [63:0] md_result;

    // operand select from scratch registers, state, sample and calibration
    function automatic logic [63:0] src_val(src_t s);
        logic [63:0] v;
        case (s)
            S_R0:   v = r0_reg;
            S_R1:   v = r1_reg;
            S_R2:   v = r2_reg;
            S_R3:   v = r3_reg;
            S_FT:   v = {{32{ft_reg[31]}}, ft_reg};
            S_RAW:  v = {44'd0, raw_reg};
            S_RAWH: v = {48'd0, raw_reg[15:0]};
            S_IMM:  v = {32'd0, ui.imm};
            S_T1:   v = {48'd0, temp_cal_reg[15:0]};
            S_T2:   v = {{48{temp_cal_reg[31]}}, temp_cal_reg[31:16]};
            S_T3:   v = {{48{temp_cal_reg[47]}}, temp_cal_reg[47:32]};
            S_P1:   v = {48'd0, press_a_reg[15:0]};
            S_P2:   v = {{48{press_a_reg[31]}}, press_a_reg[31:16]};
            S_P3:   v = {{48{press_a_reg[47]}}, press_a_reg[47:32]};
            S_P4:   v = {{48{press_a_reg[63]}}, press_a_reg[63:48]};
            S_P5:   v = {{48{press_b_reg[15]}}, press_b_reg[15:0]};
            S_P6:   v = {{48{press_b_reg[31]}}, press_b_reg[31:16]};
            S_P7:   v = {{48{press_b_reg[47]}}, press_b_reg[47:32]};
            S_P8:   v = {{48{press_b_reg[63]}}, press_b_reg[63:48]};
            S_P9:   v = {{48{press_c_reg[15]}}, press_c_reg};
            S_H1:   v = {56'd0, hum_a_reg[7:0]};
            S_H2:   v = {{48{hum_a_reg[23]}}, hum_a_reg[23:8]};
            S_H3:   v = {56'd0, hum_a_reg[31:24]};
            S_H4:   v = {{48{hum_b_reg[15]}}, hum_b_reg[15:0]};
            S_H5:   v = {{48{hum_b_reg[31]}}, hum_b_reg[31:16]};
            S_H6:   v = {{56{hum_b_reg[39]}}, hum_b_reg[39:32]};
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    // decode and combinational ALU
    always_comb
    begin
        ui = ucode(pc_reg);
        va = src_val(ui.sa);
        vb = src_val(ui.sb);
        case (ui.op)
            OP_ADD:   alu = va + vb;
            OP_SUB:   alu = va - vb;
            OP_SHL:   alu = va << ui.sh;
            OP_ASR:   alu = $unsigned($signed(va) >>> ui.sh);
            OP_CLAMP:
            begin
                if (va[63])
                    alu = 64'd0;
                else if (va > HUM_MAX)
                    alu = HUM_MAX;
                else
                    alu = va;
            end
            default:  alu = 64'd0;
        endcase
    end

    // write-back, wrapped to 32 bits in temperature and humidity mode
    always_comb
    begin
        wb_raw = (state_reg == ST_WAIT) ? md_result : alu;
        wb_val = w32_reg ? {{32{wb_raw[31]}}, wb_raw[31:0]} : wb_raw;
        wr_en  = ((state_reg == ST_EXEC) && (ui.op == OP_ADD || ui.op == OP_SUB ||
                  ui.op == OP_SHL || ui.op == OP_ASR || ui.op == OP_CLAMP)) ||
                 ((state_reg == ST_WAIT) && md_done);
        md_ctl.start  = (state_reg == ST_EXEC) && (ui.op == OP_MUL || ui.op == OP_DIV);
        md_ctl.is_div = (ui.op == OP_DIV);
        md_ctl.w32    = w32_reg;
    end

    srcomp_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (md_ctl),
        .a      (va),
        .b      (vb),
        .busy   (md_busy),
        .done   (md_done),
        .result (md_result)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        CMD_TEMP:
                        begin
                            pc_next    = PC_TEMP;
                            state_next = ST_EXEC;
                        end
                        CMD_PRESS:
                        begin
                            pc_next    = PC_PRESS;
                            state_next = ST_EXEC;
                        end
                        CMD_HUM:
                        begin
                            pc_next    = PC_HUM;
                            state_next = ST_EXEC;
                        end
                        default: state_next = ST_FIN;
                    endcase
                end
            end
            ST_EXEC:
            begin
                case (ui.op)
                    OP_MUL, OP_DIV: state_next = ST_WAIT;
                    OP_DONE:        state_next = ST_FIN;
                    OP_ZCHK:
                    begin
                        if (va == 64'd0)
                            state_next = ST_FIN;
                        else
                            pc_next = pc_reg + 7'd1;
                    end
                    default: pc_next = pc_reg + 7'd1;
                endcase
            end
            ST_WAIT:
            begin
                if (md_done)
                begin
                    pc_next    = pc_reg + 7'd1;
                    state_next = ST_EXEC;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pc_reg       <= PC_TEMP;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // calibration registers and fine temperature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg <= 48'd0;
            press_a_reg  <= 64'd0;
            press_b_reg  <= 64'd0;
            press_c_reg  <= 16'd0;
            hum_a_reg    <= 32'd0;
            hum_b_reg    <= 40'd0;
            ft_reg       <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMP:    temp_cal_reg <= cfg_data[47:0];
                    REG_PRESS_A: press_a_reg  <= cfg_data;
                    REG_PRESS_B: press_b_reg  <= cfg_data;
                    REG_PRESS_C: press_c_reg  <= cfg_data[15:0];
                    REG_HUM_A:   hum_a_reg    <= cfg_data[31:0];
                    REG_HUM_B:   hum_b_reg    <= cfg_data[39:0];
                    default:     ;
                endcase
            end
            if (wr_en && ui.dst == D_FT)
                ft_reg <= wb_val[31:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            cmd_reg <= s_tuser;
            raw_reg <= s_tdata[19:0];
            w32_reg <= (s_tuser != CMD_PRESS);
            fin_reg <= 32'd0;
        end
        if (state_reg == ST_EXEC && ui.op == OP_DONE)
            fin_reg <= va[31:0];
        if (state_reg == ST_EXEC && ui.op == OP_ZCHK && va == 64'd0)
            fin_reg <= 32'd0;
        if (wr_en)
        begin
            case (ui.dst)
                D_R0:    r0_reg <= wb_val;
                D_R1:    r1_reg <= wb_val;
                D_R2:    r2_reg <= wb_val;
                D_R3:    r3_reg <= wb_val;
                default: ;
            endcase
        end
        if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= fin_reg;
            m_tuser_reg <= cmd_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // the shared unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == ST_WAIT))
        else $error("muldiv done outside wait state");

    // no new start while the shared unit is still busy
    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        md_ctl.start |-> !md_busy)
        else $error("muldiv started while busy");

    // humidity result stays within its clamp
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == CMD_HUM) |-> (m_tdata <= 32'd102400))
        else $error("humidity result out of range");

    // unused command returns zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == CMD_NONE) |-> (m_tdata == 32'd0))
        else $error("unused command returned nonzero");

    // microprogram counter stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> (pc_reg <= PC_LAST))
        else $error("microprogram counter out of range");

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for sensor_reading_compensation: directed table, then random requests.
`timescale 1ns / 1ps
module tb
    import srcomp_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    sensor_reading_compensation i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    typedef struct {
        logic [1:0]  quantity;
        logic [31:0] value;
    } reading_t;

    // Shadow calibration and fine temperature
    logic [47:0] cal_t;
    logic [63:0] cal_pa, cal_pb;
    logic [15:0] cal_pc;
    logic [31:0] cal_ha;
    logic [39:0] cal_hb;
    logic signed [31:0] fine_t;

    reading_t expected_readings[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;

    function automatic logic signed [31:0] temp_value(input logic [19:0] raw);
        logic signed [31:0] t1, t2, t3, a, b, v1, v2, adc;
        adc = {12'd0, raw};
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        a = (adc >>> 3) - (t1 <<< 1);
        v1 = (a * t2) >>> 11;
        b = (adc >>> 4) - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        fine_t = v1 + v2;
        return ((fine_t * 5) + 128) >>> 8;
    endfunction

    function automatic logic [31:0] press_value(input logic [19:0] raw);
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, r, ft;
        ft = 64'(fine_t);
        p1 = {48'd0, cal_pa[15:0]};
        p2 = 64'($signed(cal_pa[31:16]));
        p3 = 64'($signed(cal_pa[47:32]));
        p4 = 64'($signed(cal_pa[63:48]));
        p5 = 64'($signed(cal_pb[15:0]));
        p6 = 64'($signed(cal_pb[31:16]));
        p7 = 64'($signed(cal_pb[47:32]));
        p8 = 64'($signed(cal_pb[63:48]));
        p9 = 64'($signed(cal_pc));
        v1 = ft - 64'sd128000;
        v2 = (v1 * v1) * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = (((v1 * v1) * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = ((64'sd1 <<< 47) + v1) * p1 >>> 33;
        if (v1 == 0)
            return 32'd0;
        p = 64'sd1048576 - $signed({44'd0, raw});
        p = ((p <<< 31) - v2) * 64'sd3125;
        // -2^63 / -1 wraps
        if (v1 == -64'sd1)
            p = -p;
        else
            p = p / v1;
        v1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
        v2 = (p8 * p) >>> 19;
        r = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        return r[31:0];
    endfunction

    function automatic logic [31:0] hum_value(input logic [19:0] raw);
        logic signed [31:0] h1, h2, h3, h4, h5, h6, v, a, b, s;
        h1 = {24'd0, cal_ha[7:0]};
        h2 = 32'($signed(cal_ha[23:8]));
        h3 = {24'd0, cal_ha[31:24]};
        h4 = 32'($signed(cal_hb[15:0]));
        h5 = 32'($signed(cal_hb[31:16]));
        h6 = 32'($signed(cal_hb[39:32]));
        v = fine_t - 32'sd76800;
        a = ($signed({16'd0, raw[15:0]}) <<< 14) - (h4 <<< 20) - (h5 * v);
        a = (a + 32'sd16384) >>> 15;
        b = ((v * h3) >>> 11) + 32'sd32768;
        b = (((v * h6) >>> 10) * b) >>> 10;
        b = ((b + 32'sd2097152) * h2 + 32'sd8192) >>> 14;
        v = a * b;
        s = v >>> 15;
        v = v - ((((s * s) >>> 7) * h1) >>> 4);
        if (v < 0)
            v = 0;
        if (v > 32'sd419430400)
            v = 32'sd419430400;
        return v >>> 12;
    endfunction

    function automatic reading_t compensate(input logic [1:0] cmd, input logic [19:0] raw);
        reading_t r;
        r.quantity = cmd;
        case (cmd)
            CMD_TEMP:  r.value = temp_value(raw);
            CMD_PRESS: r.value = press_value(raw);
            CMD_HUM:   r.value = hum_value(raw);
            default:   r.value = 32'd0;
        endcase
        return r;
    endfunction

    task automatic write_cal(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEMP:    cal_t  = val[47:0];
            REG_PRESS_A: cal_pa = val;
            REG_PRESS_B: cal_pb = val;
            REG_PRESS_C: cal_pc = val[15:0];
            REG_HUM_A:   cal_ha = val[31:0];
            REG_HUM_B:   cal_hb = val[39:0];
            default:     ;
        endcase
    endtask

    // Drive one request; optionally check the predictor against a typed-in value
    task automatic send_request(input logic [1:0] cmd, input logic [19:0] raw,
                                input bit known, input logic [31:0] known_val);
        reading_t r;
        do
            @(posedge clk);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, raw};
        do
            @(posedge clk);
        while (!s_tready);
        s_tvalid <= 1'b0;
        r = compensate(cmd, raw);
        if (known && r.value !== known_val)
        begin
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, known_val, r.value);
            errors++;
        end
        expected_readings.push_back(r);
    endtask

    task automatic drain();
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // Result checking
    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %0d/%h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                e = expected_readings.pop_front();
                if (m_tuser !== e.quantity || m_tdata !== e.value)
                begin
                    $display("%0t mismatch: expected %0d/%h actual %0d/%h",
                             $time, e.quantity, e.value, m_tuser, m_tdata);
                    errors++;
                end
            end
        end
    end

    // Receiver ready
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Realistic calibration set with a random spread
    task automatic typical_cal();
        write_cal(REG_TEMP, 64'({16'($urandom_range(100, 0)) - 16'd50,
                                 16'd26000 + 16'($urandom_range(2000, 0)),
                                 16'd27000 + 16'($urandom_range(2000, 0))}));
        write_cal(REG_PRESS_A, {16'd2855, -16'sd10000 + 16'($urandom_range(400, 0)),
                                -16'sd10600, 16'd36000 + 16'($urandom_range(2000, 0))});
        write_cal(REG_PRESS_B, {-16'sd12000, 16'd15500, -16'sd7, 16'sd140});
        write_cal(REG_PRESS_C, 64'd5000);
        write_cal(REG_HUM_A, 64'({8'd0, 16'd360 + 16'($urandom_range(20, 0)), 8'd75}));
        write_cal(REG_HUM_B, 64'({8'd30, 16'd50, 16'd300}));
    endtask

    typedef struct {
        logic [1:0]  cmd;
        logic [19:0] raw;
        bit          known;
        logic [31:0] val;
    } stim_row_t;

    stim_row_t dir_rows[5] = '{
        // zero calibration after reset
        '{CMD_TEMP,  20'h00000, 1'b1, 32'd0},
        '{CMD_TEMP,  20'hFFFFF, 1'b1, 32'd0},
        '{CMD_PRESS, 20'h00000, 1'b1, 32'd0},
        '{CMD_HUM,   20'hFFFFF, 1'b1, 32'd0},
        '{CMD_NONE,  20'hFFFFF, 1'b1, 32'd0}
    };

    stim_row_t cal_rows[12] = '{
        '{CMD_HUM,   20'h12345, 1'b0, 32'd0},
        '{CMD_PRESS, 20'h55555, 1'b0, 32'd0},
        '{CMD_TEMP,  20'h80000, 1'b0, 32'd0},
        '{CMD_PRESS, 20'h00000, 1'b0, 32'd0},
        '{CMD_PRESS, 20'hFFFFF, 1'b0, 32'd0},
        '{CMD_HUM,   20'h00000, 1'b0, 32'd0},
        '{CMD_HUM,   20'h0FFFF, 1'b0, 32'd0},
        '{CMD_NONE,  20'hAAAAA, 1'b1, 32'd0},
        '{CMD_TEMP,  20'h00000, 1'b0, 32'd0},
        '{CMD_TEMP,  20'hFFFFF, 1'b0, 32'd0},
        '{CMD_HUM,   20'h0FFFF, 1'b0, 32'd0},
        '{CMD_PRESS, 20'h7FFFF, 1'b0, 32'd0}
    };

    task automatic random_phase(input int n);
        logic [1:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(9, 0) < 3 ? CMD_TEMP : 2'($urandom_range(3, 0));
            if ($urandom_range(15, 0) == 0)
                c = CMD_NONE;
            send_request(c, 20'($urandom), 1'b0, 32'd0);
        end
    endtask

    initial
    begin
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_ha = '0; cal_hb = '0;
        fine_t = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].cmd, dir_rows[i].raw, dir_rows[i].known,
                         dir_rows[i].val);
        drain();

        typical_cal();
        foreach (cal_rows[i])
            send_request(cal_rows[i].cmd, cal_rows[i].raw, cal_rows[i].known,
                         cal_rows[i].val);
        drain();

        // Long receiver hold-off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(4);
        join
        drain();

        // Idle and stall phases with varied calibration
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (ph == 3)
            begin
                // all-ones extremes, with P9 at its most negative value
                write_cal(REG_TEMP, '1);
                write_cal(REG_PRESS_A, '1);
                write_cal(REG_PRESS_B, '1);
                write_cal(REG_PRESS_C, 64'h8000);
                write_cal(REG_HUM_A, '1);
                write_cal(REG_HUM_B, '1);
            end
            else if (ph == 5)
            begin
                for (int k = 0; k <= 5; k++)
                    write_cal(3'(k), rand64());
            end
            else
                typical_cal();
            random_phase(200);
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
